/* hw/rtl/ptss_pkg.sv */
package ptss_pkg;

   localparam int TASK_W    = 3;
   localparam int MASK_W    = 8;
   localparam int SEM_W     = 3;
   localparam int CNT_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 8;

   typedef enum logic [3:0] {
      CMD_TICK       = 4'd0,
      CMD_START      = 4'd1,
      CMD_SUSPEND    = 4'd2,
      CMD_RESUME     = 4'd3,
      CMD_DELAY      = 4'd4,
      CMD_PEND       = 4'd5,
      CMD_POST       = 4'd6,
      CMD_POST_SCHED = 4'd7,
      CMD_CLEAN      = 4'd8,
      CMD_SCHEDULE   = 4'd9
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_MASK  = 1'd0,
      CSR_SHARED_MASK = 1'd1
   } csr_idx_type;

   // what the counter sweep does to the cell at the head of the ring
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

endpackage

/* hw/rtl/ptss_req_if.sv */
interface ptss_req_if;
   logic                          valid;
   logic                          ready;
   logic [3:0]                    command;
   logic [ptss_pkg::TASK_W-1:0]   task_id;
   logic [ptss_pkg::SEM_W-1:0]    sem_index;
   logic [ptss_pkg::CNT_W-1:0]    tick_count;

   modport source (output valid, command, task_id, sem_index, tick_count, input ready);
   modport sink   (input valid, command, task_id, sem_index, tick_count, output ready);
endinterface

/* hw/rtl/ptss_rsp_if.sv */
interface ptss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptss_pkg::TASK_W-1:0]   running_task;
   logic [ptss_pkg::MASK_W-1:0]   ready_mask;
   logic                          pend_granted;
   logic                          switched;
   logic                          wait_left_nonzero;

   modport source (output valid, running_task, ready_mask, pend_granted, switched,
                   wait_left_nonzero, input ready);
   modport sink   (input valid, running_task, ready_mask, pend_granted, switched,
                   wait_left_nonzero, output ready);
endinterface

/* hw/rtl/ptss_cell.sv */
module ptss_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift,
   input  logic [ptss_pkg::CNT_W-1:0]   nbr_d,
   output logic [ptss_pkg::CNT_W-1:0]   cnt_q
);

   logic [ptss_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // one delay counter; the ring moves every counter one place toward the head per shift
   assign cnt_in = shift ? nbr_d : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign cnt_q = cnt_ff;

endmodule

/* hw/rtl/priority_task_scheduler_with_semaphores_unit.sv */
// Cooperative priority scheduler with semaphores. Every command word gives exactly one
// result word. At acceptance the decoded command updates the ready bitmap, the running
// task and the semaphore that it addresses. The ring of per-task delay counters then turns
// once, one cell past the head per cycle, where a tick decrements and a delay, pend,
// suspend or resume writes its counter. Next the ST_DONE state moves the result to the
// output register, and waits while the register still holds a word that has not been
// taken. A new command is taken once the previous result has moved to the output
// register.
module priority_task_scheduler_with_semaphores_unit #(
   parameter int TASK_COUNT = 7,
   parameter int SEM_COUNT  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   ptss_req_if.sink                            req,
   ptss_rsp_if.source                          rsp,
   input  logic                                csr_wr_en,
   input  logic [ptss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptss_pkg::CSR_W-1:0]          csr_wr_data
);

   localparam int SemStore = (SEM_COUNT < 8) ? SEM_COUNT : 8;
   localparam int SemIdxW  = (SemStore > 1) ? $clog2(SemStore) : 1;
   localparam logic [ptss_pkg::TASK_W-1:0] IdleTask = ptss_pkg::TASK_W'(TASK_COUNT);
   localparam logic [ptss_pkg::TASK_W-1:0] LastPos  = ptss_pkg::TASK_W'(TASK_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [ptss_pkg::CSR_W-1:0]   start_mask_ff, shared_mask_ff;
   logic [ptss_pkg::MASK_W-1:0]  ready_ff, ready_in;
   logic [ptss_pkg::TASK_W-1:0]  cur_ff, cur_in;
   logic                         sem_avail_ff [SemStore];
   logic [ptss_pkg::MASK_W-1:0]  sem_wait_ff  [SemStore];
   logic [ptss_pkg::TASK_W-1:0]  pos_ff;

   ptss_pkg::op_type             op_ff, op_in;
   logic [ptss_pkg::TASK_W-1:0]  op_task_ff, op_task_in;
   logic [ptss_pkg::CNT_W-1:0]   op_val_ff, op_val_in;
   logic                         gnt_ff, gnt_in, sw_ff, sw_in, left_ff;

   logic                         rsp_valid_ff;
   logic [ptss_pkg::TASK_W-1:0]  rsp_task_ff;
   logic [ptss_pkg::MASK_W-1:0]  rsp_mask_ff;
   logic                         rsp_gnt_ff, rsp_sw_ff, rsp_left_ff;

   logic                         accept, sweep, out_free;
   logic                         sem_ok, tid_ok, cur_ok, shared;
   logic [SemIdxW-1:0]           sidx;
   logic                         avail_rd, avail_in, sem_we;
   logic [ptss_pkg::MASK_W-1:0]  wait_rd, wait_in;
   logic [ptss_pkg::TASK_W-1:0]  wake_task;

   logic [ptss_pkg::CNT_W-1:0]   cell_q [TASK_COUNT];
   logic [ptss_pkg::CNT_W-1:0]   head_q, head_in;

   // lowest set bit among real tasks, idle when none
   function automatic logic [ptss_pkg::TASK_W-1:0] lowest_task(
      input logic [ptss_pkg::MASK_W-1:0] m
   );
      logic [ptss_pkg::TASK_W-1:0] res;
      res = IdleTask;
      for (int t = TASK_COUNT - 1; t >= 0; t--) begin
         if (m[t]) res = ptss_pkg::TASK_W'(t);
      end
      return res;
   endfunction

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign sweep     = (state_ff == ST_SWEEP);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign sem_ok   = int'(req.sem_index) < SEM_COUNT;
   assign tid_ok   = int'(req.task_id) < TASK_COUNT;
   assign cur_ok   = (cur_ff != IdleTask);
   assign shared   = shared_mask_ff[req.sem_index];
   assign sidx     = req.sem_index[SemIdxW-1:0];
   assign avail_rd = sem_ok ? sem_avail_ff[sidx] : 1'b0;
   assign wait_rd  = sem_ok ? sem_wait_ff[sidx] : '0;

   // decode of one command word
   always_comb begin
      ready_in   = ready_ff;
      cur_in     = cur_ff;
      avail_in   = avail_rd;
      wait_in    = wait_rd;
      sem_we     = 1'b0;
      gnt_in     = 1'b0;
      sw_in      = 1'b0;
      op_in      = ptss_pkg::OP_NONE;
      op_task_in = req.task_id;
      op_val_in  = '0;
      wake_task  = lowest_task(wait_rd);
      case (req.command)
         ptss_pkg::CMD_TICK: begin
            op_in = ptss_pkg::OP_TICK;
         end
         ptss_pkg::CMD_START: begin
            ready_in = start_mask_ff;
            cur_in   = IdleTask;
         end
         ptss_pkg::CMD_SUSPEND: begin
            if (tid_ok) begin
               op_in    = ptss_pkg::OP_WRITE;
               ready_in = ready_ff & ~(ptss_pkg::MASK_W'(1) << req.task_id);
               if (cur_ff == req.task_id) begin
                  cur_in = lowest_task(ready_in);
                  sw_in  = 1'b1;
               end
            end
         end
         ptss_pkg::CMD_RESUME: begin
            if (tid_ok) begin
               op_in    = ptss_pkg::OP_WRITE;
               ready_in = ready_ff | (ptss_pkg::MASK_W'(1) << req.task_id);
               if (cur_ff > req.task_id) begin
                  cur_in = lowest_task(ready_in);
                  sw_in  = 1'b1;
               end
            end
         end
         ptss_pkg::CMD_DELAY: begin
            if (req.tick_count != '0 && cur_ok) begin
               op_in      = ptss_pkg::OP_WRITE;
               op_task_in = cur_ff;
               op_val_in  = req.tick_count;
               ready_in   = ready_ff & ~(ptss_pkg::MASK_W'(1) << cur_ff);
               cur_in     = lowest_task(ready_in);
               sw_in      = 1'b1;
            end
         end
         ptss_pkg::CMD_PEND: begin
            if (sem_ok) begin
               if (avail_rd) begin
                  sem_we = 1'b1;
                  if (!shared) avail_in = 1'b0;
                  gnt_in = 1'b1;
               end else if (cur_ok) begin
                  sem_we     = 1'b1;
                  wait_in    = wait_rd | (ptss_pkg::MASK_W'(1) << cur_ff);
                  op_in      = ptss_pkg::OP_WRITE;
                  op_task_in = cur_ff;
                  op_val_in  = req.tick_count;
                  ready_in   = ready_ff & ~(ptss_pkg::MASK_W'(1) << cur_ff);
                  cur_in     = lowest_task(ready_in);
                  sw_in      = 1'b1;
               end
            end
         end
         ptss_pkg::CMD_POST, ptss_pkg::CMD_POST_SCHED: begin
            if (sem_ok) begin
               sem_we = 1'b1;
               if (shared) begin
                  avail_in = 1'b1;
                  ready_in = ready_ff | wait_rd;
                  wait_in  = '0;
               end else if (wake_task != IdleTask) begin
                  wait_in  = wait_rd & ~(ptss_pkg::MASK_W'(1) << wake_task);
                  ready_in = ready_ff | (ptss_pkg::MASK_W'(1) << wake_task);
               end else begin
                  avail_in = 1'b1;
               end
            end
            if (req.command == ptss_pkg::CMD_POST_SCHED) begin
               cur_in = lowest_task(ready_in);
               sw_in  = 1'b1;
            end
         end
         ptss_pkg::CMD_CLEAN: begin
            if (sem_ok) begin
               sem_we   = 1'b1;
               avail_in = 1'b0;
            end
         end
         ptss_pkg::CMD_SCHEDULE: begin
            cur_in = lowest_task(ready_ff);
            sw_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // counter ring: cell 0 is the head, it holds task pos_ff during a sweep
   assign head_q = cell_q[0];

   always_comb begin
      head_in = head_q;
      case (op_ff)
         ptss_pkg::OP_TICK: begin
            if (head_q != '0) head_in = head_q - ptss_pkg::CNT_W'(1);
         end
         ptss_pkg::OP_WRITE: begin
            if (op_task_ff == pos_ff) head_in = op_val_ff;
         end
         default: begin
         end
      endcase
   end

   for (genvar gi = 0; gi < TASK_COUNT; gi++) begin : g_ring
      if (gi == TASK_COUNT - 1) begin : g_tail
         ptss_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (sweep),
            .nbr_d (head_in),
            .cnt_q (cell_q[gi])
         );
      end else begin : g_body
         ptss_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (sweep),
            .nbr_d (cell_q[gi+1]),
            .cnt_q (cell_q[gi])
         );
      end
   end

   // control, configuration and scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         pos_ff         <= '0;
         start_mask_ff  <= '0;
         shared_mask_ff <= '0;
         ready_ff       <= '0;
         cur_ff         <= IdleTask;
         for (int s = 0; s < SemStore; s++) begin
            sem_avail_ff[s] <= 1'b0;
            sem_wait_ff[s]  <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               ptss_pkg::CSR_START_MASK:  start_mask_ff  <= csr_wr_data;
               ptss_pkg::CSR_SHARED_MASK: shared_mask_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && rsp.ready && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ready_ff <= ready_in;
                  cur_ff   <= cur_in;
                  if (sem_we) begin
                     sem_avail_ff[sidx] <= avail_in;
                     sem_wait_ff[sidx]  <= wait_in;
                  end
                  pos_ff   <= '0;
                  state_ff <= ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               // a counter that ticks down to zero readies its task
               if (op_ff == ptss_pkg::OP_TICK && head_q == ptss_pkg::CNT_W'(1)) begin
                  ready_ff[pos_ff] <= 1'b1;
               end
               if (pos_ff == LastPos) begin
                  pos_ff   <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  pos_ff <= pos_ff + ptss_pkg::TASK_W'(1);
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // command and result words
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_in;
         op_task_ff <= op_task_in;
         op_val_ff  <= op_val_in;
         gnt_ff     <= gnt_in;
         sw_ff      <= sw_in;
         left_ff    <= 1'b0;
      end else if (sweep && pos_ff == cur_ff) begin
         left_ff <= (head_in != '0);
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_task_ff <= cur_ff;
         rsp_mask_ff <= ready_ff;
         rsp_gnt_ff  <= gnt_ff;
         rsp_sw_ff   <= sw_ff;
         rsp_left_ff <= left_ff;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.running_task      = rsp_task_ff;
   assign rsp.ready_mask        = rsp_mask_ff;
   assign rsp.pend_granted      = rsp_gnt_ff;
   assign rsp.switched          = rsp_sw_ff;
   assign rsp.wait_left_nonzero = rsp_left_ff;

endmodule

/* hw/rtl/ptss_checker.sv */
module ptss_checker #(
   parameter int TASK_COUNT = 7
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ptss_pkg::TASK_W-1:0]       rsp_running_task,
   input logic [ptss_pkg::MASK_W-1:0]       rsp_ready_mask,
   input logic                              rsp_pend_granted,
   input logic                              rsp_switched,
   input logic                              rsp_wait_left_nonzero
);

   localparam logic [ptss_pkg::TASK_W-1:0] IdleTask = ptss_pkg::TASK_W'(TASK_COUNT);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_task)
         && $stable(rsp_ready_mask) && $stable(rsp_switched))
      else $error("stalled result word changed");

   // one command at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while the previous one is in progress");

   a_task_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_running_task <= IdleTask)
      else $error("running task beyond idle");

   a_idle_no_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_running_task == IdleTask |-> !rsp_wait_left_nonzero)
      else $error("idle task reports a pending wait");

   // an immediate grant never blocks the caller
   a_grant_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pend_granted |-> !rsp_switched)
      else $error("granted pend also rescheduled");

endmodule

bind priority_task_scheduler_with_semaphores_unit ptss_checker #(
   .TASK_COUNT (TASK_COUNT)
) u_ptss_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req.valid),
   .req_ready             (req.ready),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_running_task      (rsp.running_task),
   .rsp_ready_mask        (rsp.ready_mask),
   .rsp_pend_granted      (rsp.pend_granted),
   .rsp_switched          (rsp.switched),
   .rsp_wait_left_nonzero (rsp.wait_left_nonzero)
);
